// ===== rtl/multichannel_adc_block_averager_core_defines.svh =====
// Assertion macros shared by the block averager modules.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef MULTICHANNEL_ADC_BLOCK_AVERAGER_CORE_DEFINES_SVH
`define MULTICHANNEL_ADC_BLOCK_AVERAGER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCABA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCABA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mcaba_pkg.sv =====
package mcaba_pkg;

	// Fixed field widths.
	localparam int SAMPLE_W   = 16;
	localparam int AVG_W      = 14;
	localparam int PERIOD_W   = 16;
	localparam int MASK_W     = 8;
	localparam int CHAN_W     = 3;
	localparam int MAX_REPORT = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int STEP_W     = 4;

	// Operation codes of an input transaction.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 1'b1;

	localparam logic [PERIOD_W-1:0] ELAPSED_MAX  = 16'hFFFF;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10;
	localparam logic [STEP_W-1:0]   DIV_LAST     = STEP_W'(AVG_W - 1);

	typedef struct packed {
		logic                op;
		logic [CHAN_W-1:0]   channel;
		logic                sample_valid;
		logic [SAMPLE_W-1:0] sample_data;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_channel;
		logic [AVG_W-1:0]  average;
		logic              last;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic exec;
		logic div_load;
		logic div_step;
		logic emit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_tick;
		logic report_due;
		logic div_last;
		logic out_free;
		logic last_ch;
	} dp_status_t;

endpackage

// ===== rtl/multichannel_adc_block_averager_core.sv =====
// Multichannel block averager. Sample transactions add a valid converter result to the
// sum and count of an enabled channel; tick transactions advance a millisecond counter,
// and when it reaches the configured period the block emits one average per channel
// (the first eight at most), in channel order, with last set on the final one, clearing
// each sum and count as it is read. Each average is sum / (4 * count), or zero for a
// disabled or empty channel. A non-reporting sample or tick passes the execute state and
// returns to idle. A reporting tick keeps the input closed while, per channel, a load
// state, the shared restoring divider (one quotient bit per cycle) and an emit state
// that waits on a full output register run; that register then holds the last average
// while new transactions are accepted. No clearing pass follows reset. Configuration is
// written through cfg_we, cfg_idx (0 = channel enable mask, 1 = period in milliseconds)
// and cfg_wdata; the user must write it only while idle; the block does not enforce it.
module multichannel_adc_block_averager_core #(
	parameter int NUM_CHANNELS = 8,
	parameter int COUNT_BITS   = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  mcaba_pkg::in_item_t              in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output mcaba_pkg::out_item_t             out_item,
	input  logic                             cfg_we,
	input  logic [mcaba_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [mcaba_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import mcaba_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequencer.
	mcaba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.status   (status)
	);

	// Accumulators, divider and output register.
	mcaba_dp #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.COUNT_BITS   (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

endmodule

// ===== rtl/mcaba_dp.sv =====
module mcaba_dp #(
	parameter int NUM_CHANNELS = 8,
	parameter int COUNT_BITS   = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mcaba_pkg::in_item_t                 in_item,
	input  logic                                cfg_we,
	input  logic [mcaba_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [mcaba_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  mcaba_pkg::dp_cmd_t                  cmd,
	output mcaba_pkg::dp_status_t               status,
	input  logic                                out_ready,
	output logic                                out_valid,
	output mcaba_pkg::out_item_t                out_item
);
	import mcaba_pkg::*;

	`include "multichannel_adc_block_averager_core_defines.svh"

	localparam int SUM_W  = SAMPLE_W + COUNT_BITS;
	localparam int DVD_W  = SUM_W - 2;
	localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int RPT    = (NUM_CHANNELS > MAX_REPORT) ? MAX_REPORT : NUM_CHANNELS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [ADDR_W-1:0]     LAST_IDX  = ADDR_W'(RPT - 1);

	logic [MASK_W-1:0]     mask_q;
	logic [PERIOD_W-1:0]   period_q;
	logic [PERIOD_W-1:0]   elapsed_q;
	in_item_t              item_s1;
	logic [SUM_W-1:0]      sum_q [NUM_CHANNELS];
	logic [COUNT_BITS-1:0] count_q [NUM_CHANNELS];
	logic [ADDR_W-1:0]     idx_q;
	logic [COUNT_BITS-1:0] div_cnt_q;
	logic [COUNT_BITS:0]   rem_q;
	logic [AVG_W-1:0]      dvd_q;
	logic [AVG_W-1:0]      quo_q;
	logic [STEP_W-1:0]     step_q;
	logic                  zero_q;
	logic                  out_valid_q;
	out_item_t             out_item_q;

	logic [ADDR_W-1:0]     s_addr;
	logic                  s_in_range;
	logic                  s_take;
	logic [SUM_W-1:0]      sum_add;
	logic                  is_tick;
	logic [PERIOD_W-1:0]   el_inc;
	logic                  due;
	logic [SUM_W-1:0]      rd_sum;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic [DVD_W-1:0]      dvd_full;
	logic [COUNT_BITS:0]   div_ext;
	logic [COUNT_BITS:0]   trial;
	logic                  ge;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= '0;
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ENABLE_MASK: mask_q   <= cfg_wdata[MASK_W-1:0];
				REG_PERIOD:      period_q <= cfg_wdata[PERIOD_W-1:0];
			endcase
		end
	end

	// Input transaction is held for the execute cycle.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_s1 <= in_item;
		end
	end

	// A sample is taken only for an enabled, addressable channel whose count is not full.
	assign s_addr     = ADDR_W'(item_s1.channel);
	assign s_in_range = ({29'd0, item_s1.channel} < 32'(NUM_CHANNELS));
	assign is_tick    = (item_s1.op == OP_TICK);
	assign s_take     = cmd.exec && !is_tick && item_s1.sample_valid && s_in_range
		&& mask_q[item_s1.channel] && (count_q[s_addr] != COUNT_MAX);
	assign sum_add    = sum_q[s_addr] + SUM_W'(item_s1.sample_data);

	// Millisecond counter saturates; a report is due once it reaches the period.
	assign el_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;
	assign due    = (el_inc >= period_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
		end else if (cmd.exec && is_tick) begin
			elapsed_q <= due ? '0 : el_inc;
		end
	end

	// Per-channel sums and counts; each entry is cleared as the report reads it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				sum_q[i]   <= '0;
				count_q[i] <= '0;
			end
		end else if (s_take) begin
			sum_q[s_addr]   <= sum_add;
			count_q[s_addr] <= count_q[s_addr] + 1'b1;
		end else if (cmd.div_load) begin
			sum_q[idx_q]   <= '0;
			count_q[idx_q] <= '0;
		end
	end

	// Report channel index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.exec && is_tick && due) begin
			idx_q <= '0;
		end else if (cmd.emit && (idx_q != LAST_IDX)) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Restoring divider: (sum / 4) / count, one quotient bit per cycle. The quotient
	// always fits in the average width, so the remainder starts from the upper bits.
	assign rd_sum   = sum_q[idx_q];
	assign rd_cnt   = count_q[idx_q];
	assign dvd_full = rd_sum[SUM_W-1:2];
	assign div_ext  = {1'b0, div_cnt_q};
	assign trial    = {rem_q[COUNT_BITS-1:0], dvd_q[AVG_W-1]};
	assign ge       = (trial >= div_ext);

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q     <= {1'b0, dvd_full[DVD_W-1:AVG_W]};
			dvd_q     <= dvd_full[AVG_W-1:0];
			div_cnt_q <= rd_cnt;
			quo_q     <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? (trial - div_ext) : trial;
			dvd_q <= {dvd_q[AVG_W-2:0], 1'b0};
			quo_q <= {quo_q[AVG_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			zero_q <= 1'b1;
		end else if (cmd.div_load) begin
			step_q <= '0;
			zero_q <= !(mask_q[3'(idx_q)] && (rd_cnt != '0));
		end else if (cmd.div_step) begin
			step_q <= step_q + 1'b1;
		end
	end

	// Output register: a finished average waits here for the consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_item_q.out_channel <= CHAN_W'(idx_q);
			out_item_q.average     <= zero_q ? '0 : quo_q;
			out_item_q.last        <= (idx_q == LAST_IDX);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	assign status.is_tick    = is_tick;
	assign status.report_due = due;
	assign status.div_last   = (step_q == DIV_LAST);
	assign status.out_free   = !out_valid_q || out_ready;
	assign status.last_ch    = (idx_q == LAST_IDX);

	// While a real division is loaded, the partial remainder stays below the divisor.
	`MCABA_ASSERT_SAME(a_rem_below_divisor, !zero_q, rem_q < div_ext, "divider remainder overflow")

endmodule

// ===== rtl/mcaba_ctrl.sv =====
module mcaba_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output mcaba_pkg::dp_cmd_t    cmd,
	input  mcaba_pkg::dp_status_t status
);
	import mcaba_pkg::*;

	`include "multichannel_adc_block_averager_core_defines.svh"

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_LOAD,
		S_DIV,
		S_EMIT
	} state_t;

	state_t state_q;

	// Sequencing: accept, execute, then for a report load, divide and emit per channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (status.is_tick && status.report_due) begin
						state_q <= S_LOAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_LOAD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (status.div_last) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (status.out_free) begin
						state_q <= status.last_ch ? S_IDLE : S_LOAD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Commands to the datapath.
	assign in_ready     = (state_q == S_IDLE);
	assign cmd.accept   = in_valid && (state_q == S_IDLE);
	assign cmd.exec     = (state_q == S_EXEC);
	assign cmd.div_load = (state_q == S_LOAD);
	assign cmd.div_step = (state_q == S_DIV);
	assign cmd.emit     = (state_q == S_EMIT) && status.out_free;

	`MCABA_ASSERT_NEXT(a_report_starts, (state_q == S_EXEC) && status.is_tick && status.report_due, state_q == S_LOAD, "due report did not start")
	`MCABA_ASSERT_NEXT(a_report_ends, cmd.emit && status.last_ch, state_q == S_IDLE, "report did not end after last channel")
	`MCABA_ASSERT_NEXT(a_busy_after_accept, cmd.accept, !in_ready, "accepted a transaction while busy")

endmodule
